// ===== rtl/mcts_pkg.sv =====
// Package for the multi-channel task tick scheduler.
// Holds request kinds, channel roles, reset values and the channel control struct.
// No dependencies.
package mcts_pkg;

    localparam int MAX_CHANNELS   = 8;
    localparam int DEF_CHANNELS   = 8;
    localparam int DEF_COUNT_BITS = 16;
    localparam int SLOT_BITS      = 16;
    localparam int GROUP_SLOTS    = 4;

    localparam logic [63:0] PERIODS_LO_RESET = 64'd140739635904515000;
    localparam logic [63:0] PERIODS_HI_RESET = 64'd2814775537303552500;
    localparam logic [15:0] ROLES_RESET      = 16'd5344;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ROLE_PERIODIC    = 2'd0,
        ROLE_TIMEOUT     = 2'd1,
        ROLE_ANY_ALARM   = 2'd2,
        ROLE_BOTH_ALARMS = 2'd3
    } t_role;

    typedef enum logic [1:0] {
        CFG_PERIODS_LO = 2'd0,
        CFG_PERIODS_HI = 2'd1,
        CFG_ROLES      = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic  en;
        t_kind kind;
        logic  gate_any;
        logic  gate_both;
    } t_chan_ctrl;

endpackage

// ===== rtl/mcts_channel.sv =====
// One countdown channel of the task tick scheduler: counter and pending flag.
// Depends on mcts_pkg for request kinds, roles and the control struct.
module mcts_channel
    import mcts_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_chan_ctrl            i_ctrl,
    input  logic                  i_ack,
    input  logic                  i_alive,
    input  logic [COUNT_BITS-1:0] i_period,
    input  logic [1:0]            i_role,
    output logic                  o_pending,
    output logic                  o_expired
);

    logic [COUNT_BITS-1:0] r_cnt;
    logic [COUNT_BITS-1:0] n_cnt;
    logic                  r_pend;
    logic                  n_pend;
    logic [COUNT_BITS-1:0] w_after;
    logic                  w_hit;
    logic                  w_gate;
    t_role                 w_role;

    always_comb begin
        w_role  = t_role'(i_role);
        w_after = (w_role == ROLE_TIMEOUT && i_alive) ? i_period : r_cnt - COUNT_BITS'(1);
        w_hit   = (r_cnt != '0) && (w_after == '0);
        unique case (w_role)
            ROLE_ANY_ALARM:   w_gate = i_ctrl.gate_any;
            ROLE_BOTH_ALARMS: w_gate = i_ctrl.gate_both;
            default:          w_gate = 1'b1;
        endcase

        n_cnt     = r_cnt;
        n_pend    = r_pend;
        o_expired = 1'b0;
        unique case (i_ctrl.kind)
            KIND_TICK: begin
                if (r_cnt != '0) begin
                    n_cnt = w_hit ? i_period : w_after;
                end
                if (w_hit) begin
                    n_pend    = w_gate;
                    o_expired = 1'b1;
                end
            end
            KIND_ACK: begin
                if (i_ack) begin
                    n_pend = 1'b0;
                end
            end
            KIND_RESTART: begin
                n_cnt  = i_period;
                n_pend = 1'b0;
            end
            KIND_NONE: begin
                n_cnt = r_cnt;
            end
        endcase
        o_pending = n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pend <= 1'b0;
        end else if (i_ctrl.en) begin
            r_cnt  <= n_cnt;
            r_pend <= n_pend;
        end
    end

endmodule

// ===== rtl/multi_channel_task_tick_scheduler.sv =====
// Top level of the multi-channel task tick scheduler: request register,
// configuration registers, channel array and result register.
// Depends on mcts_pkg and mcts_channel.
// A request is captured in the request register; its result is then registered in the result register.
// Throughput: one request per cycle unless the result side stalls; all channels update in parallel in that step.
// Reset: synchronous, active low; counters idle at zero, flags clear, configuration registers at defaults.
module multi_channel_task_tick_scheduler
    import mcts_pkg::*;
#(
    parameter int CHANNELS   = DEF_CHANNELS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_ack_mask,
    input  logic [7:0]  i_alive_mask,
    input  logic        i_noise_alarm,
    input  logic        i_dust_alarm,
    input  logic        i_alarm_muted,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_pending_mask,
    output logic [7:0]  o_expired_mask,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    logic        r_in_vld;
    logic [1:0]  r_kind;
    logic [7:0]  r_ack;
    logic [7:0]  r_alive;
    logic        r_noise;
    logic        r_dust;
    logic        r_muted;
    logic        r_out_vld;
    logic [7:0]  r_pend_out;
    logic [7:0]  r_exp_out;
    logic [63:0] r_per_lo;
    logic [63:0] r_per_hi;
    logic [15:0] r_roles;
    logic        w_adv;
    t_chan_ctrl  w_ctrl;
    logic [MAX_CHANNELS-1:0] w_pend;
    logic [MAX_CHANNELS-1:0] w_exp;

    assign w_adv   = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || w_adv;

    assign w_ctrl.en        = w_adv;
    assign w_ctrl.kind      = t_kind'(r_kind);
    assign w_ctrl.gate_any  = (r_noise || r_dust) && !r_muted;
    assign w_ctrl.gate_both = (r_noise && r_dust) && !r_muted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_per_lo <= PERIODS_LO_RESET;
            r_per_hi <= PERIODS_HI_RESET;
            r_roles  <= ROLES_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PERIODS_LO: r_per_lo <= i_cfg_data;
                CFG_PERIODS_HI: r_per_hi <= i_cfg_data;
                CFG_ROLES:      r_roles  <= i_cfg_data[15:0];
                CFG_UNUSED:     r_roles  <= r_roles;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_kind  <= i_kind;
            r_ack   <= i_ack_mask;
            r_alive <= i_alive_mask;
            r_noise <= i_noise_alarm;
            r_dust  <= i_dust_alarm;
            r_muted <= i_alarm_muted;
        end
    end

    for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_ch
        if (g < CHANNELS) begin : g_on
            localparam int Slot = SLOT_BITS * (g % GROUP_SLOTS);
            logic [COUNT_BITS-1:0] w_period;

            assign w_period = (g < GROUP_SLOTS) ? r_per_lo[Slot +: COUNT_BITS]
                                                : r_per_hi[Slot +: COUNT_BITS];

            mcts_channel #(
                .COUNT_BITS (COUNT_BITS)
            ) u_channel (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl),
                .i_ack     (r_ack[g]),
                .i_alive   (r_alive[g]),
                .i_period  (w_period),
                .i_role    (r_roles[2*g +: 2]),
                .o_pending (w_pend[g]),
                .o_expired (w_exp[g])
            );
        end else begin : g_off
            assign w_pend[g] = 1'b0;
            assign w_exp[g]  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pend_out <= w_pend;
            r_exp_out  <= w_exp;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_pending_mask = r_pend_out;
    assign o_expired_mask = r_exp_out;

endmodule

// ===== rtl/mcts_checker.sv =====
// Port-level checker for the multi-channel task tick scheduler, with its bind.
// Depends on the top level's port list and its CHANNELS parameter only.
module mcts_checker #(
    parameter int CHANNELS = 8
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_pending_mask,
    input logic [7:0] o_expired_mask
);

    localparam logic [7:0] ChanMask = 8'((9'd1 << CHANNELS) - 9'd1);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid right after reset.");

    a_stall_needs_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("Request side stalled while the result side can move.");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pending_mask)
                                && $stable(o_expired_mask))
        else $error("Stalled result changed.");

    a_unused_channels_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_pending_mask | o_expired_mask) & ~ChanMask) == 8'd0)
        else $error("Flag reported for a channel beyond the channel count.");

endmodule

bind multi_channel_task_tick_scheduler mcts_checker #(
    .CHANNELS (CHANNELS)
) u_mcts_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_pending_mask (o_pending_mask),
    .o_expired_mask (o_expired_mask)
);

// ===== test/tb_multi_channel_task_tick_scheduler.sv =====
// Self-checking testbench for the multi-channel task tick scheduler.
// A scoreboard class predicts pending and expired masks per request; tasks drive the ports.
// Depends on mcts_pkg and multi_channel_task_tick_scheduler.
module tb_multi_channel_task_tick_scheduler
    import mcts_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] pending;
        logic [7:0] expired;
    } t_outcome;

    class tick_sched_scoreboard;
        logic [63:0] periods_lo;
        logic [63:0] periods_hi;
        logic [15:0] roles;
        logic [15:0] countdown [8];
        logic [7:0]  pending;
        t_outcome    due_q [$];
        int          errors;

        function new();
            periods_lo = PERIODS_LO_RESET;
            periods_hi = PERIODS_HI_RESET;
            roles      = ROLES_RESET;
            pending    = '0;
            errors     = 0;
            foreach (countdown[ch]) countdown[ch] = '0;
        endfunction

        function int outstanding();
            return due_q.size();
        endfunction

        function void write_reg(t_cfg_idx idx, logic [63:0] data);
            case (idx)
                CFG_PERIODS_LO: periods_lo = data;
                CFG_PERIODS_HI: periods_hi = data;
                CFG_ROLES:      roles = data[15:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] period_of(int ch);
            logic [63:0] grp;
            grp = (ch < 4) ? periods_lo : periods_hi;
            return grp[16 * (ch % 4) +: 16];
        endfunction

        function void note_request(t_kind kind, logic [7:0] ack, logic [7:0] alive,
                                   logic noise, logic dust, logic muted);
            t_outcome outcome;
            t_role    role;
            outcome.expired = '0;
            case (kind)
                KIND_TICK: begin
                    for (int ch = 0; ch < 8; ch++) begin
                        role = t_role'(roles[2 * ch +: 2]);
                        if (countdown[ch] != 0) begin
                            countdown[ch] = countdown[ch] - 16'd1;
                            if (role == ROLE_TIMEOUT && alive[ch])
                                countdown[ch] = period_of(ch);
                            if (countdown[ch] == 0) begin
                                countdown[ch] = period_of(ch);
                                outcome.expired[ch] = 1'b1;
                                case (role)
                                    ROLE_ANY_ALARM:   pending[ch] = (noise | dust) & ~muted;
                                    ROLE_BOTH_ALARMS: pending[ch] = (noise & dust) & ~muted;
                                    default:          pending[ch] = 1'b1;
                                endcase
                            end
                        end
                    end
                end
                KIND_ACK: begin
                    pending = pending & ~ack;
                end
                KIND_RESTART: begin
                    for (int ch = 0; ch < 8; ch++) countdown[ch] = period_of(ch);
                    pending = '0;
                end
                default: ;
            endcase
            outcome.pending = pending;
            due_q.push_back(outcome);
        endfunction

        task report_mismatch(string what, logic [7:0] want, logic [7:0] got);
            errors++;
            if (errors <= 40)
                $display("%0t ns: %s: expected %02h, got %02h", $time, what, want, got);
        endtask

        task check_result(logic [7:0] pend, logic [7:0] expd);
            t_outcome want;
            if (due_q.size() == 0) begin
                report_mismatch("result with no request outstanding", 8'h00, pend);
                return;
            end
            want = due_q.pop_front();
            if (pend !== want.pending) report_mismatch("pending_mask", want.pending, pend);
            if (expd !== want.expired) report_mismatch("expired_mask", want.expired, expd);
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_kind;
    logic [7:0]  i_ack_mask;
    logic [7:0]  i_alive_mask;
    logic        i_noise_alarm;
    logic        i_dust_alarm;
    logic        i_alarm_muted;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_pending_mask;
    logic [7:0]  o_expired_mask;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    tick_sched_scoreboard sb = new();

    multi_channel_task_tick_scheduler u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_ack_mask     (i_ack_mask),
        .i_alive_mask   (i_alive_mask),
        .i_noise_alarm  (i_noise_alarm),
        .i_dust_alarm   (i_dust_alarm),
        .i_alarm_muted  (i_alarm_muted),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pending_mask (o_pending_mask),
        .o_expired_mask (o_expired_mask),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) sb.check_result(o_pending_mask, o_expired_mask);
            if (i_valid && o_ready) begin
                sb.note_request(t_kind'(i_kind), i_ack_mask, i_alive_mask,
                                i_noise_alarm, i_dust_alarm, i_alarm_muted);
            end
        end
    end

    task automatic send_request(input t_kind kind, input logic [7:0] ack,
                                input logic [7:0] alive, input logic noise,
                                input logic dust, input logic muted);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_ack_mask    <= ack;
        i_alive_mask  <= alive;
        i_noise_alarm <= noise;
        i_dust_alarm  <= dust;
        i_alarm_muted <= muted;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
    endtask

    task automatic program_regs(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [63:0] roles_word);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PERIODS_LO;
        i_cfg_data <= lo;
        sb.write_reg(CFG_PERIODS_LO, lo);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_PERIODS_HI;
        i_cfg_data <= hi;
        sb.write_reg(CFG_PERIODS_HI, hi);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_ROLES;
        i_cfg_data <= roles_word;
        sb.write_reg(CFG_ROLES, roles_word);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_UNUSED;
        i_cfg_data <= junk;
        sb.write_reg(CFG_UNUSED, junk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    // Result side: random stalls per result, with an occasional long hold-off so
    // the block backs up and stops taking requests.
    initial begin : result_sink
        int stall;
        int taken;
        taken   = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (taken % 400 == 200)
                stall = 150;
            else
                stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!(o_valid && i_rst_n)) @(posedge i_clk);
            taken++;
        end
    end

    initial begin : stimulus
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] roles_word;
        logic [7:0]  alive;
        t_kind       kind;
        int          r;
        int          count;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_kind        = KIND_TICK;
        i_ack_mask    = '0;
        i_alive_mask  = '0;
        i_noise_alarm = 1'b0;
        i_dust_alarm  = 1'b0;
        i_alarm_muted = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_PERIODS_LO;
        i_cfg_data    = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Idle counters before any restart, the unused kind, then the reset periods.
        send_request(KIND_TICK, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b0);
        send_request(KIND_NONE, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
        send_request(KIND_ACK, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0);
        send_request(KIND_RESTART, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        send_request(KIND_TICK, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b0);
        wait_idle();

        // Short periods, at least one channel of every role, a zero period and a maximal one.
        lo = {16'd1, 16'd1, 16'd2, 16'd1};
        hi = {16'd0, 16'd3, 16'd1, 16'hFFFF};
        roles_word = {48'd0, 2'(ROLE_PERIODIC), 2'(ROLE_TIMEOUT), 2'(ROLE_TIMEOUT),
                      2'(ROLE_PERIODIC), 2'(ROLE_BOTH_ALARMS), 2'(ROLE_ANY_ALARM),
                      2'(ROLE_TIMEOUT), 2'(ROLE_PERIODIC)};
        program_regs(lo, hi, roles_word);
        send_request(KIND_RESTART, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        send_request(KIND_TICK, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0);
        send_request(KIND_TICK, 8'h00, 8'h02, 1'b1, 1'b1, 1'b1);
        send_request(KIND_TICK, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0);
        send_request(KIND_ACK, 8'h0F, 8'h00, 1'b0, 1'b0, 1'b0);
        send_request(KIND_ACK, 8'hF0, 8'h00, 1'b0, 1'b0, 1'b0);
        send_request(KIND_TICK, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
        wait_idle();

        // A running timeout channel whose period drops to zero expires at once when alive.
        hi = {16'd0, 16'd0, 16'd1, 16'hFFFF};
        program_regs(lo, hi, roles_word);
        send_request(KIND_TICK, 8'h00, 8'h40, 1'b0, 1'b0, 1'b0);
        send_request(KIND_TICK, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0);
        send_request(KIND_TICK, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        wait_idle();

        for (int phase = 0; phase < 9; phase++) begin
            if (phase == 0) begin
                lo = '0;
                hi = '0;
            end else if (phase == 1) begin
                lo = '1;
                hi = '1;
            end else begin
                for (int s = 0; s < 4; s++) begin
                    lo[16 * s +: 16] = ($urandom_range(0, 9) == 0) ? 16'd0 :
                                       16'($urandom_range(1, 6));
                    hi[16 * s +: 16] = ($urandom_range(0, 9) == 0) ? 16'd0 :
                                       16'($urandom_range(1, 6));
                end
                if (phase == 8) hi = {$urandom, $urandom};
            end
            roles_word = {$urandom, $urandom};
            case (phase)
                2: roles_word[15:0] = 16'h0000;
                3: roles_word[15:0] = 16'h5555;
                4: roles_word[15:0] = 16'hAAAA;
                5: roles_word[15:0] = 16'hFFFF;
                default: ;
            endcase
            program_regs(lo, hi, roles_word);
            send_request(KIND_RESTART, 8'($urandom), 8'($urandom), 1'b0, 1'b0, 1'b0);
            count = (phase < 2) ? 60 : 180;
            for (int n = 0; n < count; n++) begin
                r = $urandom_range(0, 99);
                if (r < 72)
                    kind = KIND_TICK;
                else if (r < 86)
                    kind = KIND_ACK;
                else if (r < 95)
                    kind = KIND_RESTART;
                else
                    kind = KIND_NONE;
                case ($urandom_range(0, 3))
                    0: alive = 8'h00;
                    1: alive = 8'hFF;
                    default: alive = 8'($urandom);
                endcase
                send_request(kind, 8'($urandom), alive, 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0));
            end
            wait_idle();
        end

        repeat (30) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("multi_channel_task_tick_scheduler verification clean");
        end else begin
            $display("multi_channel_task_tick_scheduler verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("multi_channel_task_tick_scheduler verification failed");
        $finish;
    end

endmodule

// ===== multi_channel_task_tick_scheduler.f =====
rtl/mcts_pkg.sv
rtl/mcts_channel.sv
rtl/multi_channel_task_tick_scheduler.sv
rtl/mcts_checker.sv
test/tb_multi_channel_task_tick_scheduler.sv
